@@ src/assert_macros.svh @@
// Assertion helpers, clocked on clk_i and quiet while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property that must hold at every clock edge out of reset.
`define WMM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Overlapping implication: when ante holds, cons must hold in the same cycle.
`define WMM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Non-overlapping implication: when ante holds, cons must hold in the next cycle.
`define WMM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/wmm_pkg.sv @@
package wmm_pkg;

  localparam int MAX_LEN   = 256;
  localparam int IDX_W     = $clog2(MAX_LEN);
  localparam int LEN_W     = $clog2(MAX_LEN + 1);
  localparam int POS_W     = LEN_W + 1;
  localparam int SCW       = $clog2(MAX_LEN + 2);
  localparam int SCORE_W   = 9;
  localparam int SCORE_MAX = (1 << SCORE_W) - 1;
  localparam int BYTE_W    = 8;
  localparam int CMD_W     = 2;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 16;

  localparam logic [BYTE_W-1:0] STAR_BYTE  = 8'h2A;
  localparam logic [BYTE_W-1:0] QMARK_BYTE = 8'h3F;

  typedef enum logic [CMD_W-1:0] {
    CMD_MASK = 2'd0,
    CMD_NAME = 2'd1,
    CMD_RUN  = 2'd2
  } cmd_e;

  // RFC1459 folding: a-z and { | } ~ map down by 0x20.
  function automatic logic [BYTE_W-1:0] fold_byte(input logic [BYTE_W-1:0] c);
    logic [BYTE_W-1:0] r;
    r = c;
    if (c inside {[8'h61:8'h7E]}) begin
      r = c - 8'h20;
    end
    return r;
  endfunction

endpackage

@@ src/wildcard_mask_matcher_unit.sv @@
// Load beats (mask or name byte) are taken one beat per cycle while the unit is idle.
// A run beat is taken in S_IDLE; S_STEP then does S match steps, one per cycle, paced by the
// synchronous read of the mask and name memories; backtracking to the last star adds steps.
// S_FIN passes the result on. The result waits in an output register while loads go on; a run
// that ends while an earlier result is still held stalls in S_FIN until that one leaves.
// Reset (rst_ni low, asynchronous) clears both lengths, the overflow flag, the sequencer and
// the output valid; memory contents are not cleared and are only read below the lengths.
`include "assert_macros.svh"

module wildcard_mask_matcher_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  logic [wmm_pkg::IN_TDATA_W-1:0]      s_axis_tdata_i,  // [7:0] byte_value
  input  logic [wmm_pkg::CMD_W-1:0]           s_axis_tuser_i,  // [1:0] command
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  output logic [wmm_pkg::OUT_TDATA_W-1:0]     m_axis_tdata_o   // [0] matched, [9:1] score,
                                                               // [10] overflowed, rest zero
);
  import wmm_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_STEP,
    S_FIN
  } state_e;

  state_e state_q, state_d;

  // Byte stores, one write port for loading and one registered read port each.
  logic [BYTE_W-1:0] mask_mem [MAX_LEN];
  logic [BYTE_W-1:0] name_mem [MAX_LEN];
  logic [BYTE_W-1:0] mask_rd_q, name_rd_q;

  logic [LEN_W-1:0] mask_len_q, mask_len_d, name_len_q, name_len_d;
  logic             ovf_q, ovf_d;

  // Walk positions; -1 is a legal value, so they are signed and one bit wider.
  logic signed [POS_W-1:0] mi_q, mi_d, ni_q, ni_d;
  logic signed [POS_W-1:0] save_m_q, save_m_d, save_n_q, save_n_d;
  logic signed [POS_W-1:0] save_n_dec;

  logic             have_star_q, have_star_d;
  logic             skip_q, skip_d;   // swallowing a run of stars
  logic             fb_q, fb_d;       // process the mask byte after a fallback, whatever ni
  logic [SCW-1:0]   score_q, score_d, score_sum;
  logic [LEN_W-1:0] tally_q, tally_d;
  logic [SCW-1:0]   res_q, res_d;

  logic               out_valid_q, out_valid_d;
  logic               out_matched_q, out_matched_d;
  logic [SCORE_W-1:0] out_score_q, out_score_d;
  logic               out_ovf_q, out_ovf_d;

  logic in_acc;
  cmd_e cmd;
  logic mask_full, name_full, mask_we, name_we;
  logic mi_neg, ni_neg, c_star, c_qm, lit_eq;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign cmd             = cmd_e'(s_axis_tuser_i);

  assign mask_full = (mask_len_q == LEN_W'(MAX_LEN));
  assign name_full = (name_len_q == LEN_W'(MAX_LEN));
  assign mask_we   = in_acc && (cmd == CMD_MASK) && !mask_full;
  assign name_we   = in_acc && (cmd == CMD_NAME) && !name_full;

  // Read at the next position every cycle, so the data matches mi_q / ni_q.
  always_ff @(posedge clk_i) begin
    if (mask_we) begin
      mask_mem[mask_len_q[IDX_W-1:0]] <= s_axis_tdata_i;
    end
    mask_rd_q <= mask_mem[mi_d[IDX_W-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (name_we) begin
      name_mem[name_len_q[IDX_W-1:0]] <= s_axis_tdata_i;
    end
    name_rd_q <= name_mem[ni_d[IDX_W-1:0]];
  end

  assign mi_neg     = mi_q[POS_W-1];
  assign ni_neg     = ni_q[POS_W-1];
  assign c_star     = (mask_rd_q == STAR_BYTE);
  assign c_qm       = (mask_rd_q == QMARK_BYTE);
  assign lit_eq     = (fold_byte(mask_rd_q) == fold_byte(name_rd_q));
  assign score_sum  = score_q + SCW'(tally_q);
  assign save_n_dec = save_n_q - POS_W'(1);

  always_comb begin
    state_d       = state_q;
    mask_len_d    = mask_len_q;
    name_len_d    = name_len_q;
    ovf_d         = ovf_q;
    mi_d          = mi_q;
    ni_d          = ni_q;
    save_m_d      = save_m_q;
    save_n_d      = save_n_q;
    have_star_d   = have_star_q;
    skip_d        = skip_q;
    fb_d          = fb_q;
    score_d       = score_q;
    tally_d       = tally_q;
    res_d         = res_q;
    out_valid_d   = out_valid_q && !m_axis_tready_i;
    out_matched_d = out_matched_q;
    out_score_d   = out_score_q;
    out_ovf_d     = out_ovf_q;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (cmd)
            CMD_MASK: begin
              if (mask_full) begin
                ovf_d = 1'b1;
              end else begin
                mask_len_d = mask_len_q + LEN_W'(1);
              end
            end
            CMD_NAME: begin
              if (name_full) begin
                ovf_d = 1'b1;
              end else begin
                name_len_d = name_len_q + LEN_W'(1);
              end
            end
            CMD_RUN: begin
              // Start from the last byte of each string.
              mi_d        = POS_W'(mask_len_q) - POS_W'(1);
              ni_d        = POS_W'(name_len_q) - POS_W'(1);
              save_m_d    = '0;
              save_n_d    = '0;
              have_star_d = 1'b0;
              skip_d      = 1'b0;
              fb_d        = 1'b0;
              score_d     = SCW'(1);
              tally_d     = '0;
              if (ovf_q || (mask_len_q == '0) || (name_len_q == '0)) begin
                res_d   = '0;
                state_d = S_FIN;
              end else begin
                state_d = S_STEP;
              end
            end
            default: ;
          endcase
        end
      end

      S_STEP: begin
        if (skip_q) begin
          // Drop further stars; at the first other byte, record the backtrack point.
          if (!mi_neg && c_star) begin
            mi_d = mi_q - POS_W'(1);
          end else begin
            save_m_d    = mi_q;
            save_n_d    = ni_q;
            have_star_d = 1'b1;
            score_d     = score_sum;
            tally_d     = '0;
            skip_d      = 1'b0;
            if (mi_neg) begin
              res_d   = score_sum;
              state_d = S_FIN;
            end
          end
        end else if (fb_q || (!ni_neg && !mi_neg)) begin
          fb_d = 1'b0;
          if (c_star) begin
            mi_d   = mi_q - POS_W'(1);
            skip_d = 1'b1;
          end else if (c_qm) begin
            mi_d = mi_q - POS_W'(1);
            ni_d = ni_q - POS_W'(1);
          end else if (!ni_neg && lit_eq) begin
            mi_d    = mi_q - POS_W'(1);
            ni_d    = ni_q - POS_W'(1);
            tally_d = tally_q + LEN_W'(1);
          end else if (have_star_q) begin
            // Let the last star swallow one more name byte.
            save_n_d = save_n_dec;
            ni_d     = save_n_dec;
            mi_d     = save_m_q;
            tally_d  = '0;
            if (save_n_dec[POS_W-1]) begin
              have_star_d = 1'b0;
            end
          end else begin
            res_d   = '0;
            state_d = S_FIN;
          end
        end else if (!ni_neg) begin
          // Mask used up, name left: no star fails, else fall back, take the mask byte as is.
          if (!have_star_q) begin
            res_d   = '0;
            state_d = S_FIN;
          end else begin
            save_n_d = save_n_dec;
            ni_d     = save_n_dec;
            mi_d     = save_m_q;
            tally_d  = '0;
            fb_d     = 1'b1;
            if (save_n_dec[POS_W-1]) begin
              have_star_d = 1'b0;
            end
          end
        end else begin
          // Name used up: only stars may remain in the mask.
          if (!mi_neg && c_star) begin
            mi_d = mi_q - POS_W'(1);
          end else begin
            res_d   = mi_neg ? score_sum : '0;
            state_d = S_FIN;
          end
        end
      end

      S_FIN: begin
        // Hold until the output register is free, then clear for the next pair.
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d   = 1'b1;
          out_matched_d = (res_q != '0);
          out_score_d   = (32'(res_q) > 32'(SCORE_MAX)) ? SCORE_W'(SCORE_MAX)
                                                       : SCORE_W'(res_q);
          out_ovf_d     = ovf_q;
          mask_len_d    = '0;
          name_len_d    = '0;
          ovf_d         = 1'b0;
          state_d       = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      mask_len_q    <= '0;
      name_len_q    <= '0;
      ovf_q         <= 1'b0;
      mi_q          <= '0;
      ni_q          <= '0;
      save_m_q      <= '0;
      save_n_q      <= '0;
      have_star_q   <= 1'b0;
      skip_q        <= 1'b0;
      fb_q          <= 1'b0;
      score_q       <= '0;
      tally_q       <= '0;
      res_q         <= '0;
      out_valid_q   <= 1'b0;
      out_matched_q <= 1'b0;
      out_score_q   <= '0;
      out_ovf_q     <= 1'b0;
    end else begin
      state_q       <= state_d;
      mask_len_q    <= mask_len_d;
      name_len_q    <= name_len_d;
      ovf_q         <= ovf_d;
      mi_q          <= mi_d;
      ni_q          <= ni_d;
      save_m_q      <= save_m_d;
      save_n_q      <= save_n_d;
      have_star_q   <= have_star_d;
      skip_q        <= skip_d;
      fb_q          <= fb_d;
      score_q       <= score_d;
      tally_q       <= tally_d;
      res_q         <= res_d;
      out_valid_q   <= out_valid_d;
      out_matched_q <= out_matched_d;
      out_score_q   <= out_score_d;
      out_ovf_q     <= out_ovf_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OUT_TDATA_W'({out_ovf_q, out_score_q, out_matched_q});

  `WMM_ASSERT(a_len_bound,
              (mask_len_q <= LEN_W'(MAX_LEN)) && (name_len_q <= LEN_W'(MAX_LEN)),
              "length beyond capacity")
  `WMM_ASSERT_IMP(a_ovf_nomatch, out_valid_q && out_ovf_q,
                  !out_matched_q && (out_score_q == '0), "overflow with a match")
  `WMM_ASSERT_IMP(a_match_score, out_valid_q, out_matched_q == (out_score_q != '0),
                  "matched and score disagree")
  `WMM_ASSERT_NXT(a_run_clears, (state_q == S_FIN) && (!out_valid_q || m_axis_tready_i),
                  (mask_len_q == '0) && (name_len_q == '0) && !ovf_q && out_valid_q,
                  "run did not clear")

endmodule

@@ dv/wmm_check_pkg.sv @@
`timescale 1ns / 100ps

package wmm_check_pkg;
  import wmm_pkg::*;

  // One awaited run result.
  typedef struct packed {
    logic       ovf;
    logic [8:0] score;
    logic       hit;
  } verdict_t;

  class mask_match_scoreboard;
    logic [BYTE_W-1:0] mask_bytes [MAX_LEN];
    logic [BYTE_W-1:0] name_bytes [MAX_LEN];
    int unsigned       mask_len;
    int unsigned       name_len;
    bit                spilled;
    verdict_t          pending_verdicts [$];
    int unsigned       failures;

    function new();
      mask_len = 0;
      name_len = 0;
      spilled  = 1'b0;
      failures = 0;
    endfunction

    function logic [BYTE_W-1:0] folded(input logic [BYTE_W-1:0] c);
      if (c >= 8'h61 && c <= 8'h7E) begin
        return c - 8'h20;
      end
      return c;
    endfunction

    // Walk mask and name from the end; fall back to the latest star on a miss.
    function int unsigned glob_score();
      int          mi;
      int          ni;
      int          star_m;
      int          star_n;
      bit          star_seen;
      int unsigned score;
      int unsigned run;
      star_m    = 0;
      star_n    = 0;
      star_seen = 1'b0;
      score     = 1;
      run       = 0;
      if (mask_len == 0 || name_len == 0) begin
        return 0;
      end
      mi = int'(mask_len) - 1;
      ni = int'(name_len) - 1;
      while (ni >= 0) begin
        if (mi < 0) begin
          if (!star_seen) begin
            return 0;
          end
          star_n--;
          ni  = star_n;
          mi  = star_m;
          if (ni < 0) begin
            star_seen = 1'b0;
          end
          run = 0;
        end
        if (mask_bytes[mi] == STAR_BYTE) begin
          do begin
            mi--;
          end while (mi >= 0 && mask_bytes[mi] == STAR_BYTE);
          star_m    = mi;
          star_n    = ni;
          star_seen = 1'b1;
          score    += run;
          run       = 0;
          if (mi < 0) begin
            return score;
          end
        end else if (mask_bytes[mi] == QMARK_BYTE) begin
          mi--;
          ni--;
        end else if (ni >= 0 && folded(mask_bytes[mi]) == folded(name_bytes[ni])) begin
          mi--;
          ni--;
          run++;
        end else if (star_seen) begin
          star_n--;
          ni  = star_n;
          mi  = star_m;
          if (ni < 0) begin
            star_seen = 1'b0;
          end
          run = 0;
        end else begin
          return 0;
        end
      end
      while (mi >= 0 && mask_bytes[mi] == STAR_BYTE) begin
        mi--;
      end
      return (mi >= 0) ? 0 : score + run;
    endfunction

    // Note an accepted input beat; a run beat queues one verdict and clears.
    function void note_beat(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] b);
      int unsigned score;
      verdict_t    v;
      case (cmd)
        CMD_MASK: begin
          if (mask_len < MAX_LEN) begin
            mask_bytes[mask_len] = b;
            mask_len++;
          end else begin
            spilled = 1'b1;
          end
        end
        CMD_NAME: begin
          if (name_len < MAX_LEN) begin
            name_bytes[name_len] = b;
            name_len++;
          end else begin
            spilled = 1'b1;
          end
        end
        CMD_RUN: begin
          score = spilled ? 0 : glob_score();
          if (score > SCORE_MAX) begin
            score = SCORE_MAX;
          end
          v.hit   = (score != 0);
          v.score = score[8:0];
          v.ovf   = spilled;
          pending_verdicts.push_back(v);
          mask_len = 0;
          name_len = 0;
          spilled  = 1'b0;
        end
        default: ;
      endcase
    endfunction

    function void check_result(input logic [OUT_TDATA_W-1:0] data);
      verdict_t want;
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual %h", $time, data);
        failures++;
        return;
      end
      want = pending_verdicts.pop_front();
      if (data[0] !== want.hit) begin
        $display("%0t: matched expected %0d actual %0d", $time, want.hit, data[0]);
        failures++;
      end
      if (data[9:1] !== want.score) begin
        $display("%0t: score expected %0d actual %0d", $time, want.score, data[9:1]);
        failures++;
      end
      if (data[10] !== want.ovf) begin
        $display("%0t: overflowed expected %0d actual %0d", $time, want.ovf, data[10]);
        failures++;
      end
      if (data[OUT_TDATA_W-1:11] !== '0) begin
        $display("%0t: padding expected 0 actual %h", $time, data[OUT_TDATA_W-1:11]);
        failures++;
      end
    endfunction
  endclass

endpackage

@@ dv/tb_wildcard_mask_matcher_unit.sv @@
`timescale 1ns / 100ps

module tb_wildcard_mask_matcher_unit;
  import wmm_pkg::*;
  import wmm_check_pkg::*;

  // The one command code the block must ignore.
  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

  localparam int RANDOM_ITEMS = 500;
  localparam int CALM_FROM    = 700;   // no idling on either side in this window
  localparam int CALM_TO      = 1000;
  localparam int DRAIN_CYCLES = 20;

  // Byte pool for literals: case pairs, the RFC1459 bracket pairs and edge bytes.
  localparam logic [7:0] LITERALS [16] = '{
    8'h61, 8'h41, 8'h62, 8'h42, 8'h7B, 8'h5B, 8'h7C, 8'h5C,
    8'h7D, 8'h5D, 8'h7E, 8'h5E, 8'h00, 8'hFF, 8'h7F, 8'h60
  };

  typedef logic [7:0] text_t [$];

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   s_axis_tvalid_i;
  logic                   s_axis_tready_o;
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i;   // [7:0] byte_value
  logic [CMD_W-1:0]       s_axis_tuser_i;   // [1:0] command
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;   // [0] matched, [9:1] score, [10] overflowed

  mask_match_scoreboard matcher_model = new();

  int unsigned loaded = 0;  // accepted beats, spare-code beats excluded
  bit          calm   = 1'b0;

  wildcard_mask_matcher_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic bit pause_now();
    return !calm && ($urandom_range(99) < 7);
  endfunction

  // Drive one beat and hold it until the block takes it.
  task automatic push_beat(input logic [CMD_W-1:0] cmd, input logic [7:0] b);
    while (pause_now()) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= cmd;
    s_axis_tdata_i  <= b;
    do begin
      @(posedge clk_i);
    end while (!s_axis_tready_o);
    matcher_model.note_beat(cmd, b);
    if (cmd != CMD_SPARE) begin
      loaded++;
    end
    calm = (loaded >= CALM_FROM && loaded < CALM_TO);
  endtask

  // Load mask and name in the given order (0 mask first, 1 name first, else mixed),
  // with the odd spare-code beat thrown in; finish with a run beat when asked.
  task automatic load_pair(input text_t m, input text_t n, input int order, input bit run);
    int i;
    int j;
    bit take_mask;
    i = 0;
    j = 0;
    while (i < m.size() || j < n.size()) begin
      if ($urandom_range(99) < 3) begin
        push_beat(CMD_SPARE, 8'($urandom));
      end
      if (i >= m.size()) begin
        take_mask = 1'b0;
      end else if (j >= n.size()) begin
        take_mask = 1'b1;
      end else if (order == 0) begin
        take_mask = 1'b1;
      end else if (order == 1) begin
        take_mask = 1'b0;
      end else begin
        take_mask = $urandom_range(1);
      end
      if (take_mask) begin
        push_beat(CMD_MASK, m[i]);
        i++;
      end else begin
        push_beat(CMD_NAME, n[j]);
        j++;
      end
    end
    if (run) begin
      push_beat(CMD_RUN, 8'($urandom));
    end
  endtask

  task automatic try_pair(input string m, input string n);
    text_t mt;
    text_t nt;
    for (int k = 0; k < m.len(); k++) mt.push_back(m[k]);
    for (int k = 0; k < n.len(); k++) nt.push_back(n[k]);
    load_pair(mt, nt, 0, 1'b1);
  endtask

  function automatic logic [7:0] pick_literal();
    if ($urandom_range(9) == 0) begin
      return 8'($urandom);
    end
    return LITERALS[$urandom_range(15)];
  endfunction

  // Swap a byte for its other-case partner where it has one.
  function automatic logic [7:0] case_twin(input logic [7:0] c);
    if (c >= 8'h61 && c <= 8'h7E) return c - 8'h20;
    if (c >= 8'h41 && c <= 8'h5E) return c + 8'h20;
    return c;
  endfunction

  function automatic text_t random_mask(input int len);
    text_t t;
    int    roll;
    for (int k = 0; k < len; k++) begin
      roll = $urandom_range(99);
      if (roll < 15) t.push_back(STAR_BYTE);
      else if (roll < 27) t.push_back(QMARK_BYTE);
      else t.push_back(pick_literal());
    end
    return t;
  endfunction

  // Build a name that the mask accepts: stars take 0..3 bytes, wildcards any byte.
  function automatic text_t name_for(input text_t m);
    text_t t;
    foreach (m[k]) begin
      if (m[k] == STAR_BYTE) begin
        repeat ($urandom_range(3)) t.push_back(pick_literal());
      end else if (m[k] == QMARK_BYTE) begin
        t.push_back(8'($urandom));
      end else begin
        t.push_back($urandom_range(1) ? case_twin(m[k]) : m[k]);
      end
    end
    return t;
  endfunction

  // Break a name: replace, insert or drop one byte.
  function automatic text_t spoil(input text_t n);
    text_t t;
    int    at;
    t = n;
    at = (t.size() == 0) ? 0 : $urandom_range(t.size() - 1);
    case ($urandom_range(2))
      0: if (t.size() != 0) t[at] = pick_literal(); else t.push_back(pick_literal());
      1: t.insert(at, pick_literal());
      default: if (t.size() != 0) t.delete(at);
    endcase
    return t;
  endfunction

  function automatic text_t noise_text(input int len);
    text_t t;
    repeat (len) t.push_back(8'($urandom));
    return t;
  endfunction

  function automatic text_t repeat_byte(input logic [7:0] b, input int len);
    text_t t;
    repeat (len) t.push_back(b);
    return t;
  endfunction

  // Result side: check every accepted beat, stall at random.
  initial begin
    m_axis_tready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
        matcher_model.check_result(m_axis_tdata_o);
      end
      m_axis_tready_i <= !pause_now();
    end
  end

  initial begin
    int    stop_at;
    int    kind;
    text_t m;
    text_t n;
    rst_ni          <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    s_axis_tuser_i  <= CMD_MASK;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty strings, wildcards, folding, backtracking near the name's start.
    push_beat(CMD_RUN, 8'h00);
    try_pair("a", "");
    try_pair("", "a");
    try_pair("*", "x");
    try_pair("**", "q");
    try_pair("{|}~", "[\\]^");
    try_pair("abc", "ABC");
    try_pair("a?c", "abc");
    try_pair("*ab*", "aXab");
    try_pair("a*b", "ab");
    try_pair("ab*c", "bc");
    try_pair("a*a*b", "aab");
    try_pair("*?", "z");
    push_beat(CMD_SPARE, 8'hA5);
    // Zero and top bytes are ordinary; 0x7F and 0x60 have no folded partner.
    load_pair('{8'h00, 8'hFF}, '{8'h00, 8'hFF}, 2, 1'b1);
    load_pair('{8'h7F}, '{8'h5F}, 0, 1'b1);
    load_pair('{8'h60}, '{8'h40}, 1, 1'b1);
    // Both stores full: highest score, no overflow.
    load_pair(repeat_byte(8'h61, MAX_LEN), repeat_byte(8'h41, MAX_LEN), 2, 1'b1);
    // One byte too many on either side forces no match.
    load_pair(repeat_byte(8'h61, MAX_LEN + 1), '{8'h61}, 0, 1'b1);
    load_pair('{STAR_BYTE}, repeat_byte(8'h62, MAX_LEN + 1), 1, 1'b1);

    // Random: mostly masks with names built to match, then noise and broken loads.
    stop_at = loaded + RANDOM_ITEMS;
    while (loaded < stop_at) begin
      kind = $urandom_range(99);
      if (kind == 0) begin
        m = random_mask($urandom_range(200, MAX_LEN));
        n = name_for(m);
        load_pair(m, n, $urandom_range(2), 1'b1);
      end else if (kind < 70) begin
        m = random_mask($urandom_range(1, 10));
        n = name_for(m);
        if ($urandom_range(3) == 0) n = spoil(n);
        load_pair(m, n, $urandom_range(2), 1'b1);
      end else if (kind < 85) begin
        load_pair(noise_text($urandom_range(6)), noise_text($urandom_range(6)),
                  $urandom_range(2), 1'b1);
      end else if (kind < 92) begin
        m = random_mask($urandom_range(1, 4));
        n = name_for(m);
        if ($urandom_range(1)) m.delete(); else n.delete();
        load_pair(m, n, $urandom_range(2), 1'b1);
      end else begin
        // Leave a half-loaded pair behind for the next case to append to.
        m = random_mask($urandom_range(1, 3));
        load_pair(m, name_for(m), $urandom_range(2), 1'b0);
      end
    end
    s_axis_tvalid_i <= 1'b0;

    while (matcher_model.pending_verdicts.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (matcher_model.failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Hard stop well past the slowest correct run.
  initial begin
    #50_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+src
src/wmm_pkg.sv
src/wildcard_mask_matcher_unit.sv
dv/wmm_check_pkg.sv
dv/tb_wildcard_mask_matcher_unit.sv
